// ----- hw/rtl/upq_pkg.sv -----
// shared types and constants of the unordered minimum priority queue
package upq_pkg;

    localparam int UPQ_CAPACITY  = 8;
    localparam int UPQ_VAL_W     = 32;
    localparam int UPQ_FILL_W    = 4;
    // index width for the largest supported capacity (256 cells)
    localparam int UPQ_IDX_MAX_W = 8;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    typedef struct packed {
        t_op                          operation;
        logic signed [UPQ_VAL_W-1:0]  value;
    } t_in_word;

    typedef struct packed {
        t_status                      status;
        logic signed [UPQ_VAL_W-1:0]  removed_value;
        logic [UPQ_FILL_W-1:0]        fill_count;
    } t_out_word;

    // running minimum handed from cell to cell during a remove
    typedef struct packed {
        logic                         valid;
        logic                         has;
        logic signed [UPQ_VAL_W-1:0]  val;
        logic [UPQ_IDX_MAX_W-1:0]     idx;
    } t_token;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                         wr_tail;
        logic                         shift;
        logic [UPQ_IDX_MAX_W-1:0]     sel_idx;
        logic signed [UPQ_VAL_W-1:0]  ins_val;
    } t_cell_ctrl;

endpackage

// ----- hw/rtl/upq_cell.sv -----
// one storage cell of the queue: holds an entry and passes the minimum token on
module upq_cell
    import upq_pkg::*;
#(
    parameter int CNT_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_ctrl                   i_ctrl,
    input  logic [CNT_W-1:0]             i_count,
    input  t_token                       i_tok,
    input  logic signed [UPQ_VAL_W-1:0]  i_right_val,
    output t_token                       o_tok,
    output logic signed [UPQ_VAL_W-1:0]  o_val
);

    logic signed [UPQ_VAL_W-1:0] r_val;
    t_token                      r_tok;
    t_token                      n_tok;
    logic                        occ;
    logic                        take;
    logic                        wr_here;
    logic                        shift_here;

    assign occ  = CNT_W'(CELL_IDX) < i_count;
    // strict compare keeps the earliest entry on ties
    assign take = occ && (!i_tok.has || (r_val < i_tok.val));

    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.has   = i_tok.has | occ;
        n_tok.val   = take ? r_val : i_tok.val;
        n_tok.idx   = take ? UPQ_IDX_MAX_W'(CELL_IDX) : i_tok.idx;
    end

    assign wr_here    = i_ctrl.wr_tail && (i_count == CNT_W'(CELL_IDX));
    assign shift_here = i_ctrl.shift && (UPQ_IDX_MAX_W'(CELL_IDX) >= i_ctrl.sel_idx)
                        && (CNT_W'(CELL_IDX + 1) < i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.has <= n_tok.has;
        r_tok.val <= n_tok.val;
        r_tok.idx <= n_tok.idx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_here) begin
            r_val <= i_ctrl.ins_val;
        end else if (shift_here) begin
            r_val <= i_right_val;
        end
    end

    assign o_tok = r_tok;
    assign o_val = r_val;

endmodule

// ----- hw/rtl/unordered_min_priority_queue_top.sv -----
// top level of the unordered minimum priority queue built as a chain of cells
//
// input channel: i_in_valid / o_in_ready carry one word (insert or remove-min)
// output channel: o_out_valid / i_out_ready carry one result word per input
// word, with status, removed value and fill count after the operation
// entries sit unordered in arrival order, one per cell, positions below count
// insert, overflow and underflow: result registered at the accept edge, shown
// on the next cycle, so one such word every cycle when the receiver keeps up
// remove-min: a token walks the row of cells one cell per cycle and carries
// the running minimum; when it leaves the last cell, the entries right of the
// winner all shift one cell left together and the result is registered at that
// same edge; the chain length sets the time a remove takes
// only one word is in flight; the next word is taken once the block is idle
// reset (synchronous, active low) empties the queue and drops any pending
// result; cell contents are not cleared, the count keeps them unread
// receiver stall: the result word waits in the output register, and a new
// word is accepted only in a cycle where that register is empty or drained
module unordered_min_priority_queue_top
    import upq_pkg::*;
#(
    parameter int CAPACITY = UPQ_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // count must hold CAPACITY itself
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // one-hot sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                      r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    t_out_word                   r_out, n_out;
    t_cell_ctrl                  ctrl;
    logic                        inject;
    logic                        in_acc;
    logic                        full;

    // token chain: w_tok[i] enters cell i, w_tok[CAPACITY] leaves the last cell
    t_token                      w_tok [CAPACITY+1];
    logic signed [UPQ_VAL_W-1:0] w_val [CAPACITY];

    // fill count is the low bits of the entry count
    function automatic logic [UPQ_FILL_W-1:0] fill_of(input logic [CNT_W-1:0] c);
        logic [CNT_W+UPQ_FILL_W-1:0] ext;
        ext = {{UPQ_FILL_W{1'b0}}, c};
        return ext[UPQ_FILL_W-1:0];
    endfunction

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(CAPACITY));

    // a fresh token enters cell 0 on the accept of a remove from a non-empty queue
    assign w_tok[0] = '{valid: inject, has: 1'b0, val: '0, idx: '0};

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        inject       = 1'b0;
        ctrl.wr_tail = 1'b0;
        ctrl.shift   = 1'b0;
        ctrl.sel_idx = w_tok[CAPACITY].idx;
        ctrl.ins_val = i_in_word.value;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.operation == OP_INSERT) begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_out = '{status: ST_OVERFLOW, removed_value: '0,
                                      fill_count: fill_of(r_count)};
                        end else begin
                            ctrl.wr_tail = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_out = '{status: ST_INSERTED, removed_value: '0,
                                      fill_count: fill_of(r_count + CNT_W'(1))};
                        end
                    end else if (r_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out = '{status: ST_UNDERFLOW, removed_value: '0,
                                  fill_count: fill_of(r_count)};
                    end else begin
                        inject  = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // token out of the last cell names the earliest minimum
                if (w_tok[CAPACITY].valid) begin
                    ctrl.shift  = 1'b1;
                    n_count     = r_count - CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_REMOVED, removed_value: w_tok[CAPACITY].val,
                              fill_count: fill_of(r_count - CNT_W'(1))};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    // row of cells; each hands its token right and its entry left
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [UPQ_VAL_W-1:0] right_val;

        if (gi == CAPACITY - 1) begin : g_last
            assign right_val = w_val[gi];
        end else begin : g_mid
            assign right_val = w_val[gi+1];
        end

        upq_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_count     (r_count),
            .i_tok       (w_tok[gi]),
            .i_right_val (right_val),
            .o_tok       (w_tok[gi+1]),
            .o_val       (w_val[gi])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

// ----- hw/rtl/upq_checker.sv -----
// port-level checker of the priority queue top and its bind
module upq_checker
    import upq_pkg::*;
#(
    parameter int CAPACITY = UPQ_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // no new word taken while an unread result would be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid || i_out_ready)
        else $error("input ready while result pending");

    // removed value is zero on every other status
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status != ST_REMOVED)
        |-> o_out_word.removed_value == '0)
        else $error("nonzero removed value without removal");

    // fill count never above capacity
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> int'(o_out_word.fill_count) <= CAPACITY)
        else $error("fill count above capacity");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind unordered_min_priority_queue_top upq_checker #(
    .CAPACITY (CAPACITY)
) u_upq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
